// ===== rtl/core/fir_pkg.sv =====
// ----------------------------------------------------------------------------
// fir_pkg
// Shared constants, command codes and types of the loadable-tap FIR filter.
// ----------------------------------------------------------------------------
package fir_pkg;

   localparam int MAX_TAPS_DEF = 256;
   localparam int SAMPLE_W_DEF = 16;
   localparam int COEF_W_DEF   = 18;

   localparam int TAP_COUNT_W  = 9;
   localparam int FUNC_W       = 2;

   localparam int CMD_DEPTH    = 4;
   localparam int RSP_DEPTH    = 2;

   localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

// ===== rtl/core/fir_filter_loadable_taps.sv =====
// ----------------------------------------------------------------------------
// fir_filter_loadable_taps
// A sample with N taps in use is written into the history; the states run,
// drain, round, shift and out follow; with no taps it goes straight to out.
// Loads write the coefficient store as they leave the command queue. The
// single shared multiply-accumulate reads one history and one coefficient word
// per cycle; no command leaves the queue until the last one is done. A clear
// zeroes every history word; so does the pass on reset, with full held high.
// ----------------------------------------------------------------------------
module fir_filter_loadable_taps #(
   parameter int MAX_TAPS     = fir_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_WIDTH = fir_pkg::SAMPLE_W_DEF,
   parameter int COEF_WIDTH   = fir_pkg::COEF_W_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [fir_pkg::FUNC_W-1:0]          req_func,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_sample,
   input  logic [7:0]                          req_coef_index,
   input  logic signed [COEF_WIDTH-1:0]        req_coef_value,
   output logic                                empty,
   input  logic                                pop,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_filtered,
   output logic                                rsp_saturated,
   input  logic                                valid,
   output logic                                ready,
   input  logic [fir_pkg::TAP_COUNT_W-1:0]     csr_tap_count
);

   localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CMD_W = fir_pkg::FUNC_W + SAMPLE_WIDTH + AW + COEF_WIDTH;

   logic [fir_pkg::TAP_COUNT_W-1:0] tap_count_ff, tap_count_in;
   logic                            init_busy;
   logic                            cmd_push, cmd_pop;
   logic [CMD_W-1:0]                cmd_wdata, cmd_rdata;
   fir_pkg::fifo_stat_type          cmd_stat;
   logic                            rsp_push;
   logic [SAMPLE_WIDTH:0]           rsp_wdata, rsp_rdata;
   fir_pkg::fifo_stat_type          rsp_stat;

   assign ready        = 1'b1;
   assign tap_count_in = valid ? csr_tap_count : tap_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= '0;
      end else begin
         tap_count_ff <= tap_count_in;
      end
   end

   fir_front #(
      .MAX_TAPS     (MAX_TAPS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
   ) u_front (
      .push           (push),
      .full           (full),
      .req_func       (req_func),
      .req_sample     (req_sample),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .init_busy      (init_busy),
      .cmd_stat       (cmd_stat),
      .cmd_push       (cmd_push),
      .cmd_data       (cmd_wdata)
   );

   fir_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (fir_pkg::CMD_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wdata),
      .pop     (cmd_pop),
      .rd_data (cmd_rdata),
      .stat    (cmd_stat)
   );

   fir_back #(
      .MAX_TAPS     (MAX_TAPS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tap_count (tap_count_ff),
      .cmd_data  (cmd_rdata),
      .cmd_stat  (cmd_stat),
      .cmd_pop   (cmd_pop),
      .rsp_stat  (rsp_stat),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wdata),
      .init_busy (init_busy)
   );

   fir_fifo #(
      .WIDTH (SAMPLE_WIDTH + 1),
      .DEPTH (fir_pkg::RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_wdata),
      .pop     (pop),
      .rd_data (rsp_rdata),
      .stat    (rsp_stat)
   );

   assign empty         = rsp_stat.empty;
   assign rsp_filtered  = rsp_rdata[SAMPLE_WIDTH-1:0];
   assign rsp_saturated = rsp_rdata[SAMPLE_WIDTH];

endmodule

// ===== rtl/core/fir_ram.sv =====
// ----------------------------------------------------------------------------
// fir_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fir_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/fir_fifo.sv =====
// ----------------------------------------------------------------------------
// fir_fifo
// Small register-based first-in first-out queue with full and empty status.
// ----------------------------------------------------------------------------
module fir_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  pop,
   output logic [WIDTH-1:0]      rd_data,
   output fir_pkg::fifo_stat_type stat
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push & ~stat.full;
   assign do_pop     = pop & ~stat.empty;
   assign rd_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/core/fir_front.sv =====
// ----------------------------------------------------------------------------
// fir_front
// Input side: accepts commands, drops those that do nothing, queues the rest.
// ----------------------------------------------------------------------------
module fir_front #(
   parameter int MAX_TAPS     = fir_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_WIDTH = fir_pkg::SAMPLE_W_DEF,
   parameter int COEF_WIDTH   = fir_pkg::COEF_W_DEF
) (
   input  logic                           push,
   output logic                           full,
   input  logic [fir_pkg::FUNC_W-1:0]     req_func,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic [7:0]                     req_coef_index,
   input  logic signed [COEF_WIDTH-1:0]   req_coef_value,
   input  logic                           init_busy,
   input  fir_pkg::fifo_stat_type         cmd_stat,
   output logic                           cmd_push,
   output logic [fir_pkg::FUNC_W+SAMPLE_WIDTH+((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)
                 +COEF_WIDTH-1:0]         cmd_data
);

   localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

   logic [31:0] idx_wide;
   logic        known_func;
   logic        load_in_range;
   logic        keep;

   assign idx_wide      = 32'(req_coef_index);
   assign known_func    = req_func inside {fir_pkg::FUNC_SAMPLE, fir_pkg::FUNC_LOAD,
                                           fir_pkg::FUNC_CLEAR};
   assign load_in_range = (idx_wide < 32'(MAX_TAPS));

   // drop unused codes and loads that fall outside the store
   assign keep = known_func & ((req_func != fir_pkg::FUNC_LOAD) | load_in_range);

   assign full     = cmd_stat.full | init_busy;
   assign cmd_push = push & ~full & keep;
   assign cmd_data = {req_func, req_sample, idx_wide[AW-1:0], req_coef_value};

endmodule

// ===== rtl/core/fir_back.sv =====
// ----------------------------------------------------------------------------
// fir_back
// Execution side: coefficient and history stores, shared multiply-accumulate,
// rounding and saturation, history clearing sweep.
// ----------------------------------------------------------------------------
module fir_back #(
   parameter int MAX_TAPS     = fir_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_WIDTH = fir_pkg::SAMPLE_W_DEF,
   parameter int COEF_WIDTH   = fir_pkg::COEF_W_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [fir_pkg::TAP_COUNT_W-1:0]     tap_count,
   input  logic [fir_pkg::FUNC_W+SAMPLE_WIDTH+((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)
                 +COEF_WIDTH-1:0]              cmd_data,
   input  fir_pkg::fifo_stat_type              cmd_stat,
   output logic                                cmd_pop,
   input  fir_pkg::fifo_stat_type              rsp_stat,
   output logic                                rsp_push,
   output logic [SAMPLE_WIDTH:0]               rsp_data,
   output logic                                init_busy
);

   localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CNT_W = $clog2(MAX_TAPS + 1);
   localparam int PW    = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACC_W = (PW + AW + 1 > 64) ? 64 : PW + AW + 1;

   localparam logic signed [ACC_W-1:0] ROUND_ONE =
      {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_WIDTH - 2);
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_RUN   = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_ROUND = 3'd4;
   localparam logic [2:0] ST_SHIFT = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0] a,
      input logic signed [ACC_W-1:0] b
   );
      logic signed [ACC_W-1:0] s;
      s = a + b;
      if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
         s = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
      end
      return s;
   endfunction

   logic [fir_pkg::FUNC_W-1:0]     c_func;
   logic [SAMPLE_WIDTH-1:0]        c_sample;
   logic [AW-1:0]                  c_index;
   logic [COEF_WIDTH-1:0]          c_value;

   logic [2:0]                     state_ff, state_in;
   logic                           init_ff, init_in;
   logic [AW-1:0]                  clr_addr_ff, clr_addr_in;
   logic [AW-1:0]                  wp_ff, wp_in;
   logic [AW-1:0]                  hidx_ff, hidx_in;
   logic [AW-1:0]                  k_ff, k_in;
   logic                           v1_ff, v1_in;
   logic                           v2_ff;
   logic signed [PW-1:0]           prod_ff;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic [SAMPLE_WIDTH:0]          res_ff, res_in;

   logic [CNT_W-1:0]               n, n_m1, p_inc;
   logic [AW-1:0]                  p;

   logic                           coef_we;
   logic [COEF_WIDTH-1:0]          coef_rd;
   logic                           hist_we;
   logic [AW-1:0]                  hist_wa;
   logic [SAMPLE_WIDTH-1:0]        hist_wd;
   logic [SAMPLE_WIDTH-1:0]        hist_rd;

   logic signed [ACC_W-1:0]        shifted;
   logic [ACC_W-SAMPLE_WIDTH:0]    upper;
   logic                           fits;

   assign {c_func, c_sample, c_index, c_value} = cmd_data;

   // taps in use, counts above the store size act as the store size
   assign n     = (32'(tap_count) > 32'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : CNT_W'(tap_count);
   assign n_m1  = n - CNT_W'(1);
   // a pointer left over from a larger count restarts at zero
   assign p     = (CNT_W'(wp_ff) < n) ? wp_ff : '0;
   assign p_inc = CNT_W'(p) + CNT_W'(1);

   assign shifted = acc_ff >>> (COEF_WIDTH - 1);
   assign upper   = shifted[ACC_W-1:SAMPLE_WIDTH-1];
   assign fits    = (&upper) | ~(|upper);

   fir_ram #(
      .WIDTH (COEF_WIDTH),
      .DEPTH (MAX_TAPS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (c_index),
      .wr_data (c_value),
      .rd_addr (k_ff),
      .rd_data (coef_rd)
   );

   fir_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (MAX_TAPS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_wa),
      .wr_data (hist_wd),
      .rd_addr (hidx_ff),
      .rd_data (hist_rd)
   );

   always_comb begin
      state_in    = state_ff;
      init_in     = init_ff;
      clr_addr_in = clr_addr_ff;
      wp_in       = wp_ff;
      hidx_in     = hidx_ff;
      k_in        = k_ff;
      v1_in       = 1'b0;
      res_in      = res_ff;
      acc_in      = acc_ff;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      coef_we     = 1'b0;
      hist_we     = 1'b0;
      hist_wa     = p;
      hist_wd     = c_sample;

      if (v2_ff) begin
         acc_in = sat_add(acc_ff, ACC_W'(prod_ff));
      end

      case (state_ff)
         ST_CLEAR: begin
            hist_we = 1'b1;
            hist_wa = clr_addr_ff;
            hist_wd = '0;
            wp_in   = '0;
            if (clr_addr_ff == AW'(MAX_TAPS - 1)) begin
               state_in = ST_IDLE;
               init_in  = 1'b0;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (!cmd_stat.empty) begin
               cmd_pop = 1'b1;
               case (c_func)
                  fir_pkg::FUNC_LOAD: begin
                     coef_we = 1'b1;
                  end
                  fir_pkg::FUNC_CLEAR: begin
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end
                  fir_pkg::FUNC_SAMPLE: begin
                     if (n == '0) begin
                        res_in   = {1'b0, c_sample};
                        state_in = ST_OUT;
                     end else begin
                        // store the new sample, then walk newest to oldest
                        hist_we  = 1'b1;
                        hidx_in  = p;
                        k_in     = n_m1[AW-1:0];
                        acc_in   = '0;
                        wp_in    = (p_inc == n) ? '0 : p_inc[AW-1:0];
                        state_in = ST_RUN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            v1_in = 1'b1;
            if (k_ff == '0) begin
               state_in = ST_DRAIN;
            end else begin
               k_in    = k_ff - 1'b1;
               hidx_in = (hidx_ff == '0) ? n_m1[AW-1:0] : hidx_ff - 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            acc_in   = sat_add(acc_ff, ROUND_ONE);
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (fits) begin
               res_in = {1'b0, shifted[SAMPLE_WIDTH-1:0]};
            end else begin
               res_in = {1'b1, shifted[ACC_W-1] ? OUT_MIN : OUT_MAX};
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the result queue has room
            if (!rsp_stat.full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         init_ff     <= 1'b1;
         clr_addr_ff <= '0;
         wp_ff       <= '0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         init_ff     <= init_in;
         clr_addr_ff <= clr_addr_in;
         wp_ff       <= wp_in;
         v1_ff       <= v1_in;
         v2_ff       <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      hidx_ff <= hidx_in;
      k_ff    <= k_in;
      prod_ff <= $signed(coef_rd) * $signed(hist_rd);
      acc_ff  <= acc_in;
      res_ff  <= res_in;
   end

   assign rsp_data  = res_ff;
   assign init_busy = init_ff;

endmodule

// ===== rtl/core/fir_checker.sv =====
// ----------------------------------------------------------------------------
// fir_checker
// Port-level checks of the FIR filter, bound to the top level.
// ----------------------------------------------------------------------------
module fir_checker #(
   parameter int SAMPLE_WIDTH = fir_pkg::SAMPLE_W_DEF
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    full,
   input logic                    empty,
   input logic                    pop,
   input logic [SAMPLE_WIDTH-1:0] rsp_filtered,
   input logic                    rsp_saturated
);

   // the clearing pass after reset refuses input
   a_full_after_reset: assert property (@(posedge clock) reset |=> full)
      else $error("input taken during post-reset clearing pass");

   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("result present right after reset");

   a_beat_held: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty)
      else $error("waiting result beat dropped");

   a_beat_stable: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> ($stable(rsp_filtered) && $stable(rsp_saturated)))
      else $error("waiting result beat changed");

endmodule

bind fir_filter_loadable_taps fir_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_checker (
   .clock         (clock),
   .reset         (reset),
   .full          (full),
   .empty         (empty),
   .pop           (pop),
   .rsp_filtered  (rsp_filtered),
   .rsp_saturated (rsp_saturated)
);

// ===== tb/sv/fir_response_check.sv =====
// ----------------------------------------------------------------------------
// fir_response_check
// Watches the command, result and tap-count channels of the loadable-tap FIR
// filter, predicts every filter output and compares it with the block.
// ----------------------------------------------------------------------------
module fir_response_check
   import fir_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic                         full,
   input  logic [FUNC_W-1:0]            req_func,
   input  logic signed [SAMPLE_W_DEF-1:0] req_sample,
   input  logic [7:0]                   req_coef_index,
   input  logic signed [COEF_W_DEF-1:0] req_coef_value,
   input  logic                         empty,
   input  logic                         pop,
   input  logic signed [SAMPLE_W_DEF-1:0] rsp_filtered,
   input  logic                         rsp_saturated,
   input  logic                         valid,
   input  logic                         ready,
   input  logic [TAP_COUNT_W-1:0]       csr_tap_count,
   output int                           errors,
   output int                           awaiting,
   output int                           checked,
   output int                           clipped
);

   localparam longint OUT_MAX = (longint'(1) <<< (SAMPLE_W_DEF - 1)) - 1;
   localparam longint OUT_MIN = -OUT_MAX - 1;

   typedef struct packed {
      logic signed [SAMPLE_W_DEF-1:0] filtered;
      logic                           saturated;
   } fir_out_type;

   fir_out_type                    expected_q[$];
   logic signed [COEF_W_DEF-1:0]   taps [MAX_TAPS_DEF];
   logic signed [SAMPLE_W_DEF-1:0] history [MAX_TAPS_DEF];
   int unsigned                    next_slot;
   logic [TAP_COUNT_W-1:0]         tap_count;
   int                             fail_count;
   int                             result_count;
   int                             clip_count;

   // Enter the sample into the circular history and form the tap sum.
   function automatic fir_out_type filter_sample(input logic signed [SAMPLE_W_DEF-1:0] x);
      fir_out_type r;
      int unsigned n;
      int unsigned p;
      int unsigned h;
      longint      acc;
      longint      y;
      r.filtered  = x;
      r.saturated = 1'b0;
      n = (tap_count > MAX_TAPS_DEF) ? MAX_TAPS_DEF : tap_count;
      if (n == 0)
         return r;
      // a pointer left over from a larger count restarts at slot zero
      p = (next_slot < n) ? next_slot : 0;
      history[p] = x;
      acc = 0;
      for (int unsigned j = 0; j < n; j++) begin
         h = (j <= p) ? p - j : p + n - j;
         acc += longint'(taps[n - 1 - j]) * longint'(history[h]);
      end
      next_slot = (p + 1 == n) ? 0 : p + 1;
      // round half up to Q1.15, then clip
      y = (acc + (longint'(1) <<< (COEF_W_DEF - 2))) >>> (COEF_W_DEF - 1);
      if (y > OUT_MAX) begin
         y = OUT_MAX;
         r.saturated = 1'b1;
      end else if (y < OUT_MIN) begin
         y = OUT_MIN;
         r.saturated = 1'b1;
      end
      r.filtered = y[SAMPLE_W_DEF-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      fir_out_type want;
      if (reset) begin
         expected_q.delete();
         foreach (history[i]) history[i] = '0;
         next_slot    = 0;
         tap_count    = '0;
         fail_count   = 0;
         result_count = 0;
         clip_count   = 0;
      end else begin
         if (pop && !empty) begin
            if (expected_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, got %0d/%0b",
                        $time, rsp_filtered, rsp_saturated);
            end else begin
               want = expected_q.pop_front();
               if (rsp_filtered !== want.filtered) begin
                  fail_count++;
                  $display("%0t: filtered expected %0d, got %0d",
                           $time, want.filtered, rsp_filtered);
               end
               if (rsp_saturated !== want.saturated) begin
                  fail_count++;
                  $display("%0t: saturated expected %0b, got %0b",
                           $time, want.saturated, rsp_saturated);
               end
               result_count++;
               if (want.saturated)
                  clip_count++;
            end
         end
         if (valid && ready)
            tap_count = csr_tap_count;
         if (push && !full) begin
            case (req_func)
               FUNC_SAMPLE: expected_q.push_back(filter_sample(req_sample));
               FUNC_LOAD:   taps[req_coef_index] = req_coef_value;
               FUNC_CLEAR: begin
                  foreach (history[i]) history[i] = '0;
                  next_slot = 0;
               end
               default: ;
            endcase
         end
      end
      errors   <= fail_count;
      awaiting <= expected_q.size();
      checked  <= result_count;
      clipped  <= clip_count;
   end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives the loadable-tap FIR filter with directed and random commands over a
// range of tap counts, under bursty input and a stalling result side, and
// reports the verdict from the response checker's failure and outstanding counts.
// ----------------------------------------------------------------------------
module tb;
   import fir_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int QUIET_CYCLES = 4 * (MAX_TAPS_DEF + 8) + 64;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int HOLD_CYCLES  = 800;

   logic                           clock;
   logic                           reset;
   logic                           push;
   logic                           full;
   logic [FUNC_W-1:0]              req_func;
   logic signed [SAMPLE_W_DEF-1:0] req_sample;
   logic [7:0]                     req_coef_index;
   logic signed [COEF_W_DEF-1:0]   req_coef_value;
   logic                           empty;
   logic                           pop;
   logic signed [SAMPLE_W_DEF-1:0] rsp_filtered;
   logic                           rsp_saturated;
   logic                           valid;
   logic                           ready;
   logic [TAP_COUNT_W-1:0]         csr_tap_count;

   int     errors;
   int     awaiting;
   int     checked;
   int     clipped;
   bit     coef_written [MAX_TAPS_DEF];
   int     burst_left;
   int     commands_sent;
   int     input_stalls;
   int     settings_used;
   bit     hold_armed;
   bit     hold_done;
   longint cycles = 0;

   fir_filter_loadable_taps dut (.*);

   fir_response_check response_check (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side: stall on a changing pattern, plus one long hold-off.
   initial begin : receiver
      int mode;
      int mode_left;
      pop       = 1'b0;
      hold_done = 1'b0;
      mode      = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (hold_armed && !hold_done) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(10, 150);
         end
         mode_left--;
         case (mode)
            0:       pop <= 1'b1;
            1:       pop <= $urandom_range(0, 1);
            default: pop <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   function automatic logic signed [SAMPLE_W_DEF-1:0] rand_sample();
      int t;
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: begin
            t = $urandom_range(0, 511) - 256;
            return t[SAMPLE_W_DEF-1:0];
         end
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [COEF_W_DEF-1:0] rand_coef();
      int t;
      case ($urandom_range(0, 7))
         0:    return 18'h1FFFF;
         1:    return 18'h20000;
         2, 3: return 18'($urandom);
         default: begin
            t = $urandom_range(0, 4095) - 2048;
            return t[COEF_W_DEF-1:0];
         end
      endcase
   endfunction

   // Offer one command beat; open a fresh burst after a random gap.
   task automatic offer(input logic [FUNC_W-1:0] f, input logic signed [SAMPLE_W_DEF-1:0] s,
                        input logic [7:0] ci, input logic signed [COEF_W_DEF-1:0] cv);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      push           <= 1'b1;
      req_func       <= f;
      req_sample     <= s;
      req_coef_index <= ci;
      req_coef_value <= cv;
      @(posedge clock);
      while (full) begin
         input_stalls++;
         @(posedge clock);
      end
      commands_sent++;
   endtask

   task automatic send_sample(input logic signed [SAMPLE_W_DEF-1:0] s);
      offer(FUNC_SAMPLE, s, 8'($urandom), 18'($urandom));
   endtask

   task automatic load_coef(input int idx, input logic signed [COEF_W_DEF-1:0] v);
      coef_written[idx] = 1'b1;
      offer(FUNC_LOAD, rand_sample(), idx[7:0], v);
   endtask

   // Drop push, drain every expected result, then let queued clears finish.
   task automatic settle();
      push <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_taps(input int v);
      settle();
      valid         <= 1'b1;
      csr_tap_count <= v[TAP_COUNT_W-1:0];
      @(posedge clock);
      while (!ready) @(posedge clock);
      valid <= 1'b0;
      settings_used++;
   endtask

   task automatic run_phase(input int v, input int items, input bit arm_hold);
      int n;
      int pick;
      n = (v > MAX_TAPS_DEF) ? MAX_TAPS_DEF : v;
      write_taps(v);
      // leave the history alone half the time so a stale pointer shows up
      if ($urandom_range(0, 1))
         offer(FUNC_CLEAR, rand_sample(), 8'($urandom), 18'($urandom));
      for (int i = 0; i < n; i++)
         if (!coef_written[i])
            load_coef(i, rand_coef());
      // start the long hold-off while commands keep coming
      if (arm_hold)
         hold_armed = 1'b1;
      repeat (items) begin
         pick = $urandom_range(0, 99);
         if (pick < 75)
            send_sample(rand_sample());
         else if (pick < 90)
            load_coef($urandom_range(0, MAX_TAPS_DEF - 1), rand_coef());
         else if (pick < 95)
            offer(FUNC_CLEAR, rand_sample(), 8'($urandom), 18'($urandom));
         else
            offer(FUNC_UNUSED, rand_sample(), 8'($urandom), 18'($urandom));
      end
   endtask

   initial begin : stimulus
      int plan [12];
      plan           = '{2, 256, 17, 0, 511, 8, 1, 64, 3, 255, 12, 257};
      reset          = 1'b1;
      push           = 1'b0;
      valid          = 1'b0;
      req_func       = FUNC_SAMPLE;
      req_sample     = '0;
      req_coef_index = '0;
      req_coef_value = '0;
      csr_tap_count  = '0;
      burst_left     = 0;
      commands_sent  = 0;
      input_stalls   = 0;
      settings_used  = 0;
      hold_armed     = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // pass-through at the reset tap count, extremes of the sample
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h0000);
      send_sample(16'hFFFF);
      offer(FUNC_UNUSED, 16'h7FFF, 8'hFF, 18'h3FFFF);
      load_coef(0, 18'h20000);
      load_coef(1, 18'h1FFFF);
      load_coef(2, 18'h1FFFF);
      load_coef(MAX_TAPS_DEF - 1, 18'h1FFFF);
      offer(FUNC_CLEAR, 16'h8000, 8'h00, 18'h00000);

      // single tap of -1.0: most negative sample clips high
      write_taps(1);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'h0001);

      // three taps (two near +1.0, one of -1.0) overflow the output range
      write_taps(3);
      send_sample(16'h7FFF);
      send_sample(16'h7FFF);

      // shrink the count without a clear: pointer sits past the end
      write_taps(2);
      send_sample(16'h8000);
      send_sample(16'h4000);

      foreach (plan[i])
         run_phase(plan[i], (plan[i] >= 64) ? 14 : 30, i == 0);

      settle();
      $display("Sent %0d commands across %0d tap-count settings (0 to 511, stale pointer)",
               commands_sent, settings_used);
      $display("Checked %0d results, %0d clipped; input held off for %0d cycles",
               checked, clipped, input_stalls);
      if (errors == 0 && awaiting == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/fir_pkg.sv
rtl/core/fir_ram.sv
rtl/core/fir_fifo.sv
rtl/core/fir_front.sv
rtl/core/fir_back.sv
rtl/core/fir_filter_loadable_taps.sv
rtl/core/fir_checker.sv
tb/sv/fir_response_check.sv
tb/sv/tb.sv
